FILE: rtl/core/clcd_pkg.sv
// Shared types and constants for the character LCD 4-bit controller.
package clcd_pkg;

    localparam int MEM_CELLS = 80;
    localparam int COLS      = 16;
    localparam int MEM_IDX_W = $clog2(MEM_CELLS);

    localparam int CURSOR_W = 7;
    localparam int CHAR_W   = 8;
    localparam int NIB_W    = 4;
    localparam int COL_W    = 4;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    // Item kinds carried on the slave tuser bit
    localparam logic OP_PIN  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Register select levels
    localparam logic RS_CMD  = 1'b0;

    // Command bytes and init nibbles
    localparam logic [CHAR_W-1:0] CMD_CLEAR   = 8'h01;
    localparam logic [CHAR_W-1:0] CMD_HOME    = 8'h02;
    localparam logic [NIB_W-1:0]  INIT_NIB_A  = 4'h2;
    localparam logic [NIB_W-1:0]  INIT_NIB_B  = 4'h3;
    localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_NONE   = 8'h00;

    // Controller state kept between items
    typedef struct packed {
        logic [CURSOR_W-1:0] cursor;
        logic [NIB_W-1:0]    high_half;
        logic                pending;
        logic                last_en;
    } clcd_state_t;

    // Display memory write request
    typedef struct packed {
        logic                 we;
        logic                 clear;
        logic [MEM_IDX_W-1:0] addr;
        logic [CHAR_W-1:0]    data;
    } clcd_wr_t;

endpackage

FILE: rtl/core/char_lcd_4bit_controller.sv
// Top level of the character LCD 4-bit bus controller.
// Usage:
//   The slave stream carries one item per transaction. tuser[0] is the kind:
//   0 = pin update (port byte, register select and enable level as seen on the
//   LCD bus), 1 = read of the character shown at a row and column.
//   A falling edge of enable across two pin updates latches DB4-DB7 (port bits
//   7..4); two nibbles, high then low, form a command or data byte.
//   The master stream returns one result per accepted item: the character read
//   (0 for pin updates), the cursor after the item, the pending-nibble flag and
//   a flag that a byte was completed and executed.
//   Path: an item passes through two stages, the input register and then the
//   result register, before its result appears on the master side.
//   Throughput: one item per cycle unless stalled; the display memory has one
//   write and one registered read port and each item uses at most one of them.
//   The clear command drops all per-cell valid bits at once, so the whole
//   display reads as spaces.
//   Reset: cursor, nibble state and enable history go to zero and every cell
//   reads as a space; no clearing pass is needed, items are taken right away.
//   Stall: when the master side holds tready low, the result register holds,
//   one more item waits in the input register, then tready drops.
module char_lcd_4bit_controller
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [7:0] port_byte, [8] reg_select, [9] enable_pin, [10] row, [14:11] column
    input  logic [clcd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [0] op
    input  logic [0:0]                           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [7:0] shown_char, [14:8] cursor, [15] nibble_pending, [16] byte_done
    output logic [clcd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    // input register
    logic                              in_valid_reg;
    logic                              in_op_reg;
    logic [clcd_pkg::CHAR_W-1:0]       in_port_reg;
    logic                              in_rs_reg;
    logic                              in_en_reg;
    logic                              in_row_reg;
    logic [clcd_pkg::COL_W-1:0]        in_col_reg;

    // result register (read data lives in the memory's read register)
    logic                              out_valid_reg;
    logic                              out_op_reg;
    logic                              out_hit_reg;
    logic [clcd_pkg::CURSOR_W-1:0]     out_cursor_reg;
    logic                              out_pend_reg;
    logic                              out_done_reg;

    clcd_pkg::clcd_state_t             state_reg;
    clcd_pkg::clcd_state_t             state_next;
    clcd_pkg::clcd_wr_t                wr;
    logic                              done_next;
    logic                              advance;
    logic                              take_in;
    logic                              pin_fire;
    logic                              read_fire;
    logic [clcd_pkg::CURSOR_W-1:0]     rd_full_addr;
    logic                              rd_hit;
    logic [clcd_pkg::CHAR_W-1:0]       rd_data;
    logic [clcd_pkg::CHAR_W-1:0]       shown_char;

    // move the input stage forward when the result stage is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign take_in       = s_axis_tvalid && s_axis_tready;
    assign pin_fire      = advance && (in_op_reg == clcd_pkg::OP_PIN);
    assign read_fire     = advance && (in_op_reg == clcd_pkg::OP_READ);

    // address row*0x40+column; outside the visible columns reads a space
    assign rd_full_addr = {in_row_reg, 2'b00, in_col_reg};
    assign rd_hit       = ({2'b00, in_col_reg} < 6'(clcd_pkg::COLS)) &&
                          ({1'b0, rd_full_addr} < 8'(clcd_pkg::MEM_CELLS));

    clcd_decode u_decode
    (
        .active     (pin_fire),
        .state      (state_reg),
        .port_byte  (in_port_reg),
        .reg_select (in_rs_reg),
        .enable_pin (in_en_reg),
        .state_next (state_next),
        .wr         (wr),
        .byte_done  (done_next)
    );

    clcd_mem u_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_en   (read_fire),
        .rd_addr (rd_full_addr[clcd_pkg::MEM_IDX_W-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (take_in)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_op_reg   <= s_axis_tuser[0];
            in_port_reg <= s_axis_tdata[7:0];
            in_rs_reg   <= s_axis_tdata[8];
            in_en_reg   <= s_axis_tdata[9];
            in_row_reg  <= s_axis_tdata[10];
            in_col_reg  <= s_axis_tdata[14:11];
        end
        if (advance)
        begin
            out_op_reg     <= in_op_reg;
            out_hit_reg    <= rd_hit;
            out_cursor_reg <= state_next.cursor;
            out_pend_reg   <= state_next.pending;
            out_done_reg   <= done_next;
        end
    end

    always_comb
    begin
        if (out_op_reg == clcd_pkg::OP_READ)
        begin
            shown_char = out_hit_reg ? rd_data : clcd_pkg::CHAR_SPACE;
        end
        else
        begin
            shown_char = clcd_pkg::CHAR_NONE;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_done_reg, out_pend_reg, out_cursor_reg, shown_char};

`ifndef SYNTHESIS
    // a completed byte always leaves no nibble pending
    a_done_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_done_reg |-> !out_pend_reg)
        else $error("byte completed with a nibble still pending");

    // reads never complete a byte
    a_read_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_op_reg == clcd_pkg::OP_READ) |-> !out_done_reg)
        else $error("read item reported a completed byte");

    // reads leave controller state untouched
    a_read_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        read_fire |=> $stable(state_reg))
        else $error("read item changed controller state");

    // memory is never written and cleared together
    a_wr_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr.we && wr.clear))
        else $error("display memory write and clear in the same cycle");

    // an item stalled in the input stage stays there
    a_in_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input stage dropped a stalled item");
`endif

endmodule

FILE: rtl/core/clcd_decode.sv
// Nibble assembly and command decode for one pin update.
module clcd_decode
(
    input  logic                              active,
    input  clcd_pkg::clcd_state_t             state,
    input  logic [clcd_pkg::CHAR_W-1:0]       port_byte,
    input  logic                              reg_select,
    input  logic                              enable_pin,
    output clcd_pkg::clcd_state_t             state_next,
    output clcd_pkg::clcd_wr_t                wr,
    output logic                              byte_done
);

    logic                            falling;
    logic                            init_nib;
    logic [clcd_pkg::NIB_W-1:0]      nib;
    logic [clcd_pkg::CHAR_W-1:0]     joined_byte;
    logic                            in_range;

    assign nib         = port_byte[7:4];
    assign joined_byte = {state.high_half, nib};
    assign falling     = state.last_en && !enable_pin;
    assign init_nib    = (reg_select == clcd_pkg::RS_CMD) && !state.pending &&
                         ((nib == clcd_pkg::INIT_NIB_A) || (nib == clcd_pkg::INIT_NIB_B));
    assign in_range    = {1'b0, state.cursor} < 8'(clcd_pkg::MEM_CELLS);

    always_comb
    begin
        state_next         = state;
        state_next.last_en = enable_pin;
        wr.we              = 1'b0;
        wr.clear           = 1'b0;
        wr.addr            = state.cursor[clcd_pkg::MEM_IDX_W-1:0];
        wr.data            = joined_byte;
        byte_done          = 1'b0;

        if (falling && !init_nib)
        begin
            if (!state.pending)
            begin
                // latch the upper half and wait for the lower one
                state_next.high_half = nib;
                state_next.pending   = 1'b1;
            end
            else
            begin
                state_next.pending = 1'b0;
                byte_done          = 1'b1;
                if (reg_select == clcd_pkg::RS_CMD)
                begin
                    if (joined_byte[7])
                    begin
                        state_next.cursor = joined_byte[6:0];
                    end
                    else if (joined_byte == clcd_pkg::CMD_CLEAR)
                    begin
                        wr.clear          = 1'b1;
                        state_next.cursor = '0;
                    end
                    else if (joined_byte == clcd_pkg::CMD_HOME)
                    begin
                        state_next.cursor = '0;
                    end
                end
                else if (in_range)
                begin
                    wr.we             = 1'b1;
                    state_next.cursor = state.cursor + 7'd1;
                end
            end
        end

        // hold everything for read items and idle cycles
        if (!active)
        begin
            state_next = state;
            wr.we      = 1'b0;
            wr.clear   = 1'b0;
            byte_done  = 1'b0;
        end
    end

endmodule

FILE: rtl/core/clcd_mem.sv
// Display memory with per-cell valid bits; an invalid cell reads as a space.
module clcd_mem
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  clcd_pkg::clcd_wr_t                wr,
    input  logic                              rd_en,
    input  logic [clcd_pkg::MEM_IDX_W-1:0]    rd_addr,
    output logic [clcd_pkg::CHAR_W-1:0]       rd_data
);

    logic [clcd_pkg::CHAR_W-1:0]     mem [clcd_pkg::MEM_CELLS];
    logic [clcd_pkg::MEM_CELLS-1:0]  valid_reg;
    logic [clcd_pkg::CHAR_W-1:0]     rd_raw_reg;
    logic                            rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_raw_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
            if (wr.clear)
            begin
                valid_reg <= '0;
            end
            else if (wr.we)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_raw_reg : clcd_pkg::CHAR_SPACE;

endmodule
